@@ sv/ripq_pkg.sv @@
package ripq_pkg;

	localparam int IDX_W   = 12;
	localparam int COUNT_W = 32;

	typedef enum logic {
		ACT_ADD   = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef logic [COUNT_W-1:0] count_t;

	// one node access per cycle: clear write, plain read, or read-increment-write
	typedef struct packed {
		logic rd;
		logic bump;
		logic clr;
	} mem_op_t;

	function automatic count_t sat_inc(input count_t x);
		return (&x) ? x : x + count_t'(1);
	endfunction

	function automatic count_t sat_add(input count_t a, input count_t b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
	endfunction

endpackage

@@ sv/ripq_node_mem.sv @@
module ripq_node_mem #(
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ripq_pkg::mem_op_t op,
	input  logic [ADDR_W-1:0] addr,
	output logic              rd_valid,
	output ripq_pkg::count_t  rd_data
);
	import ripq_pkg::*;

	localparam int DEPTH = 2 ** ADDR_W;

	count_t mem [DEPTH];

	logic              rd_s1;
	logic              bump_s1;
	logic [ADDR_W-1:0] addr_s1;
	count_t            rdata_s1;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	count_t            wr_data;

	// the increment is written back in the cycle after its read
	assign wr_en   = op.clr | bump_s1;
	assign wr_addr = op.clr ? addr : addr_s1;
	assign wr_data = op.clr ? '0 : sat_inc(rdata_s1);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (op.rd)
			rdata_s1 <= (wr_en && (wr_addr == addr)) ? wr_data : mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			bump_s1 <= 1'b0;
		end else begin
			rd_s1   <= op.rd;
			bump_s1 <= op.rd & op.bump;
		end
	end

	always_ff @(posedge clk) begin
		if (op.rd)
			addr_s1 <= addr;
	end

	assign rd_valid = rd_s1 & ~bump_s1;
	assign rd_data  = rdata_s1;

endmodule

@@ sv/range_increment_point_query_tree.sv @@
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------------------
// request  | req_valid | req_stall | action, range_low, range_high, point
// response | rsp_valid | rsp_stall | cover_count
//
// After reset every node memory word (8192 at the default) is cleared to
// zero, with req_stall high. All node accesses go through one memory
// port, one node per cycle: a query reads one node per tree level, leaf
// to root; an increment updates up to two nodes per tree level. One
// request at a time; a finished result waits in the output register
// while the next request is taken.
module range_increment_point_query_tree #(
	parameter int LEAF_COUNT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              action,
	input  logic [ripq_pkg::IDX_W-1:0]        range_low,
	input  logic [ripq_pkg::IDX_W-1:0]        range_high,
	input  logic [ripq_pkg::IDX_W-1:0]        point,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [ripq_pkg::COUNT_W-1:0]      cover_count
);
	import ripq_pkg::*;

	localparam int LEAF_AW = $clog2(LEAF_COUNT);
	localparam int NODE_AW = LEAF_AW + 1;
	localparam int EDGE_W  = NODE_AW + 1;
	localparam int CMP_W   = (LEAF_AW > IDX_W) ? LEAF_AW : IDX_W;

	localparam logic [EDGE_W-1:0] SPAN_E = {2'b01, {LEAF_AW{1'b0}}};
	localparam logic [CMP_W-1:0]  LAST_C = CMP_W'(LEAF_COUNT - 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_ADD    = 6'b000100,
		ST_QUERY  = 6'b001000,
		ST_QTAIL  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t             state_q;
	logic [NODE_AW-1:0] clr_q;
	logic [EDGE_W-1:0]  left_q;
	logic [EDGE_W-1:0]  right_q;
	logic [NODE_AW-1:0] idx_q;
	count_t             sum_q;
	logic               rsp_valid_q;
	count_t             cover_count_q;

	logic               accept;
	logic               slot_free;
	logic [CMP_W-1:0]   lo_c;
	logic [CMP_W-1:0]   hi_c;
	logic [CMP_W-1:0]   pt_c;
	logic [EDGE_W-1:0]  right_m1;
	logic               walking;

	mem_op_t            op;
	logic [NODE_AW-1:0] mem_addr;
	logic               rd_valid;
	count_t             rd_data;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid & ~req_stall;
	assign slot_free = ~rsp_valid_q | ~rsp_stall;

	assign lo_c     = CMP_W'(range_low);
	assign hi_c     = (CMP_W'(range_high) > LAST_C) ? LAST_C : CMP_W'(range_high);
	assign pt_c     = CMP_W'(point);
	assign right_m1 = right_q - EDGE_W'(1);
	assign walking  = (left_q < right_q);

	always_comb begin
		op       = '0;
		mem_addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				op.clr   = 1'b1;
				mem_addr = clr_q;
			end
			ST_ADD: begin
				if (walking && (left_q[0] || right_q[0])) begin
					op.rd    = 1'b1;
					op.bump  = 1'b1;
					mem_addr = left_q[0] ? left_q[NODE_AW-1:0] : right_m1[NODE_AW-1:0];
				end
			end
			ST_QUERY: begin
				op.rd    = 1'b1;
				mem_addr = idx_q;
			end
			ST_IDLE, ST_QTAIL, ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	ripq_node_mem #(
		.ADDR_W (NODE_AW)
	) u_node_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.addr     (mem_addr),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && slot_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NODE_AW'(1);
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_QUERY)
							state_q <= (pt_c <= LAST_C) ? ST_QUERY : ST_RESULT;
						else if (lo_c <= hi_c)
							state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!walking)
						state_q <= ST_IDLE;
				end
				ST_QUERY: begin
					if (idx_q == NODE_AW'(1))
						state_q <= ST_QTAIL;
				end
				ST_QTAIL: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			left_q  <= SPAN_E + EDGE_W'(lo_c[LEAF_AW-1:0]);
			right_q <= SPAN_E + EDGE_W'(hi_c[LEAF_AW-1:0]) + EDGE_W'(1);
			idx_q   <= {1'b1, pt_c[LEAF_AW-1:0]};
			sum_q   <= '0;
		end else begin
			if (state_q == ST_ADD && walking) begin
				priority if (left_q[0] && right_q[0]) begin
					left_q <= left_q + EDGE_W'(1);
				end else if (left_q[0]) begin
					left_q  <= (left_q + EDGE_W'(1)) >> 1;
					right_q <= right_q >> 1;
				end else begin
					left_q  <= left_q >> 1;
					right_q <= right_q >> 1;
				end
			end
			if (state_q == ST_QUERY)
				idx_q <= idx_q >> 1;
			if (rd_valid)
				sum_q <= sat_add(sum_q, rd_data);
		end
		if (state_q == ST_RESULT && slot_free)
			cover_count_q <= sum_q;
	end

	assign rsp_valid   = rsp_valid_q;
	assign cover_count = cover_count_q;

endmodule

@@ bench/cover_count_checker.sv @@
module cover_count_checker #(
	parameter int LEAVES = 4096
) (
	input  logic                         clk,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic                         action,
	input  logic [ripq_pkg::IDX_W-1:0]   range_low,
	input  logic [ripq_pkg::IDX_W-1:0]   range_high,
	input  logic [ripq_pkg::IDX_W-1:0]   point,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic [ripq_pkg::COUNT_W-1:0] cover_count,
	output int                           fails,
	output int                           pending
);

	import ripq_pkg::*;

	localparam int SPAN = 1 << $clog2(LEAVES);

	count_t node_cnt [1:2*SPAN-1];
	count_t expected_cover [$];

	initial begin
		for (int n = 1; n < 2*SPAN; n++)
			node_cnt[n] = '0;
		fails = 0;
		pending = 0;
	end

	function automatic void raise_node(input int unsigned n);
		if (node_cnt[n] != {COUNT_W{1'b1}})
			node_cnt[n] = node_cnt[n] + 1'b1;
	endfunction

	// cover [lo, hi] with the minimal node set, walking both ends upwards
	function automatic void add_cover(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
		int unsigned l, r, last;
		last = hi;
		if (last > LEAVES - 1)
			last = LEAVES - 1;
		if (lo > last)
			return;
		l = SPAN + lo;
		r = SPAN + last + 1;
		while (l < r) begin
			if ((l & 1) != 0) begin
				raise_node(l);
				l++;
			end
			if ((r & 1) != 0) begin
				r--;
				raise_node(r);
			end
			l = l >> 1;
			r = r >> 1;
		end
	endfunction

	function automatic count_t leaf_cover(input logic [IDX_W-1:0] leaf);
		int unsigned n;
		logic [COUNT_W:0] acc;
		if (leaf > LEAVES - 1)
			return '0;
		acc = '0;
		n = SPAN + leaf;
		while (n > 0) begin
			acc = acc + node_cnt[n];
			if (acc[COUNT_W])
				acc = {1'b0, {COUNT_W{1'b1}}};
			n = n >> 1;
		end
		return acc[COUNT_W-1:0];
	endfunction

	// response first: a result leaving in the same cycle belongs to an earlier query
	always @(posedge clk) begin : watch
		count_t want;
		if (rsp_valid && !rsp_stall) begin
			if (expected_cover.size() == 0) begin
				$display("%0t: cover_count expected none, got %0d", $time, cover_count);
				fails = fails + 1;
			end else begin
				want = expected_cover.pop_front();
				if (cover_count !== want) begin
					$display("%0t: cover_count expected %0d, got %0d", $time, want,
						cover_count);
					fails = fails + 1;
				end
			end
		end
		if (req_valid && !req_stall) begin
			if (action == ACT_QUERY)
				expected_cover.insert(expected_cover.size(), leaf_cover(point));
			else
				add_cover(range_low, range_high);
		end
		pending <= expected_cover.size();
	end

endmodule

@@ bench/range_increment_point_query_tree_tb.sv @@
module range_increment_point_query_tree_tb;

	import ripq_pkg::*;

	localparam int LEAVES = 4096;
	localparam int RANDOM_ITEMS = 950;
	localparam int LIMIT = 1000000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               action;
	logic [IDX_W-1:0]   range_low;
	logic [IDX_W-1:0]   range_high;
	logic [IDX_W-1:0]   point;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [COUNT_W-1:0] cover_count;

	int fail_count;
	int pending_count;
	int cycles;
	int stall_left;
	bit steady;
	logic [IDX_W-1:0] bounds [$];

	range_increment_point_query_tree #(
		.LEAF_COUNT(LEAVES)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.range_low  (range_low),
		.range_high (range_high),
		.point      (point),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cover_count(cover_count)
	);

	cover_count_checker #(
		.LEAVES(LEAVES)
	) checker_i (
		.clk        (clk),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.range_low  (range_low),
		.range_high (range_high),
		.point      (point),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cover_count(cover_count),
		.fails      (fail_count),
		.pending    (pending_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("range_increment_point_query_tree: mismatch");
		$finish;
	end

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin : result_backpressure
		int r;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else if (steady) begin
			rsp_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				rsp_stall <= 1'b0;
				stall_left = $urandom_range(0, 6);
			end else if (r < 93) begin
				rsp_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				rsp_stall <= 1'b1;
				stall_left = $urandom_range(9, 39);
			end
		end
	end

	task automatic send(input action_t act, input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi, input logic [IDX_W-1:0] pt);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req_valid  <= 1'b1;
		action     <= act;
		range_low  <= lo;
		range_high <= hi;
		point      <= pt;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	task automatic random_item();
		int k;
		logic [IDX_W-1:0] a, b, p, t;
		k = $urandom_range(0, 99);
		a = IDX_W'($urandom);
		b = IDX_W'($urandom);
		p = IDX_W'($urandom);
		if (k < 45) begin
			// probe around recent range ends, where off-by-one faults show
			if ($urandom_range(0, 2) != 0 && bounds.size() > 0)
				p = IDX_W'(bounds[$urandom_range(0, bounds.size() - 1)]
					+ $urandom_range(0, 2) - 1);
			send(ACT_QUERY, a, b, p);
		end else if (k < 52) begin
			if (a == b)
				a = a | 1'b1;
			if (a == 0)
				a = 1;
			if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			if (a == b)
				b = a - 1'b1;
			send(ACT_ADD, a, b, p);
		end else begin
			if (k < 75) begin
				b = (a > LEAVES - 17) ? IDX_W'(LEAVES - 1)
					: IDX_W'(a + $urandom_range(0, 15));
			end else if (k < 82) begin
				b = a;
			end else if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			bounds.insert(bounds.size(), a);
			bounds.insert(bounds.size(), b);
			while (bounds.size() > 16)
				void'(bounds.pop_front());
			send(ACT_ADD, a, b, p);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		action     = ACT_ADD;
		range_low  = '0;
		range_high = '0;
		point      = '0;
		rsp_stall  = 1'b0;
		stall_left = 0;
		steady     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(ACT_QUERY, 12'hFFF, 12'hFFF, 12'd0);
		send(ACT_ADD,   12'd0, 12'd4095, 12'd4095);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd0);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd4095);
		send(ACT_ADD,   12'd4095, 12'd4095, 12'd0);
		send(ACT_ADD,   12'd0, 12'd0, 12'hFFF);
		send(ACT_QUERY, 12'd5, 12'd3, 12'd4095);
		send(ACT_QUERY, 12'd0, 12'd4095, 12'd0);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd2048);
		// empty ranges: low above high
		send(ACT_ADD,   12'd4095, 12'd0, 12'd0);
		send(ACT_ADD,   12'd101, 12'd100, 12'd100);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd100);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd4095);
		send(ACT_ADD,   12'd1, 12'd4094, 12'd0);
		send(ACT_ADD,   12'd2047, 12'd2048, 12'd0);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd2047);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd2048);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd1);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd4094);
		send(ACT_ADD,   12'd0, 12'd4094, 12'd0);
		send(ACT_ADD,   12'd1, 12'd4095, 12'd0);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd4095);
		send(ACT_QUERY, 12'd0, 12'd0, 12'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				steady = ($urandom_range(0, 3) == 0);
			random_item();
		end
		steady = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("range_increment_point_query_tree: match");
		else
			$display("range_increment_point_query_tree: mismatch");
		$finish;
	end

endmodule
